// ----- src/pilm_pkg.sv -----
`default_nettype none

package pilm_pkg;

    localparam int LITERAL_LEN = 7;

    typedef enum logic [1:0] {
        VERDICT_NO_MATCH = 2'd0,
        VERDICT_MATCH    = 2'd1,
        VERDICT_SHORT    = 2'd2
    } verdict_t;

    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_F  = 8'h66;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_F  = 8'h46;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= CHAR_0) && (c <= CHAR_9);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_dec(c) || ((c >= CHAR_LO_A) && (c <= CHAR_LO_F))
            || ((c >= CHAR_UP_A) && (c <= CHAR_UP_F));
    endfunction

    // Characters of " ipp://" in order.
    function automatic logic [7:0] literal_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h20;
            3'd1:    c = 8'h69;
            3'd2:    c = 8'h70;
            3'd3:    c = 8'h70;
            3'd4:    c = 8'h3a;
            3'd5:    c = 8'h2f;
            3'd6:    c = 8'h2f;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- src/printer_idle_line_matcher_top.sv -----
// Printer idle line matcher.
// The slave stream carries one payload byte per word in s_tdata, with s_tlast
// on the final byte of each payload. The master stream carries one verdict per
// payload in m_tdata[1:0]: no match, matched, or a payload too short to judge.
// A verdict appears only for words with s_tlast set.
// Each byte is checked by a small phase machine in the cycle it is accepted,
// and the verdict is registered, so it shows on the master side in the
// cycle after the last byte is accepted. One byte is taken every cycle,
// but not a last byte behind a stalled verdict. A pending verdict that
// the receiver stalls holds in the output register; bytes without s_tlast
// are still accepted meanwhile, while a last byte waits until the pending
// verdict is taken. Synchronous reset clears the phase machine, the position
// count and the output valid, so the first byte after reset starts a new
// payload. The position count saturates just above the largest limit, which
// does not change any verdict.
`default_nettype none

module printer_idle_line_matcher_top #(
    parameter int MIN_PAYLOAD        = 20,
    parameter int FIRST_FIELD_LIMIT  = 8,
    parameter int SECOND_FIELD_LIMIT = 12
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] payload_byte
    input  wire logic       s_tlast,   // last_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata    // [1:0] verdict, [7:2] zero
);
    import pilm_pkg::*;

    localparam int LIMIT_MAX = (MIN_PAYLOAD > SECOND_FIELD_LIMIT) ?
        ((MIN_PAYLOAD > FIRST_FIELD_LIMIT) ? MIN_PAYLOAD : FIRST_FIELD_LIMIT) :
        ((SECOND_FIELD_LIMIT > FIRST_FIELD_LIMIT) ? SECOND_FIELD_LIMIT
                                                  : FIRST_FIELD_LIMIT);
    localparam int POS_CAP = LIMIT_MAX + 1;
    localparam int PW      = $clog2(POS_CAP + 1);

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_FIRST,
        PH_SECOND_LEAD,
        PH_SECOND,
        PH_LITERAL,
        PH_DONE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [2:0]  lit_reg, lit_next;
    logic        found_reg, found_next;
    logic        m_valid_reg;
    verdict_t    verdict_reg, verdict_next;
    logic        accept;
    logic        lit_hit;

    assign s_tready = !m_valid_reg || m_tready || !s_tlast;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, verdict_reg};

    always_comb begin
        logic [2:0] k;
        k          = (phase_reg == PH_SECOND) ? 3'd0 : lit_reg;
        phase_next = phase_reg;
        lit_next   = lit_reg;
        found_next = found_reg;
        lit_hit    = (s_tdata == literal_char(k)) && (k < 3'(LITERAL_LEN));
        unique case (phase_reg)
            PH_LEAD: begin
                phase_next = is_dec(s_tdata) ? PH_FIRST : PH_DONE;
            end
            PH_FIRST: begin
                if (!((pos_reg <= PW'(FIRST_FIELD_LIMIT)) && is_hex(s_tdata))) begin
                    phase_next = (s_tdata == CHAR_SPACE) ? PH_SECOND_LEAD : PH_DONE;
                end
            end
            PH_SECOND_LEAD: begin
                phase_next = is_dec(s_tdata) ? PH_SECOND : PH_DONE;
            end
            PH_SECOND, PH_LITERAL: begin
                if (phase_reg == PH_LITERAL
                    || !((pos_reg <= PW'(SECOND_FIELD_LIMIT)) && is_dec(s_tdata))) begin
                    lit_next = k;
                    if (!lit_hit) begin
                        phase_next = PH_DONE;
                    end else begin
                        lit_next = k + 3'd1;
                        if (k + 3'd1 == 3'(LITERAL_LEN)) begin
                            found_next = 1'b1;
                            phase_next = PH_DONE;
                        end else begin
                            phase_next = PH_LITERAL;
                        end
                    end
                end
            end
            default: begin
                phase_next = PH_DONE;
            end
        endcase

        pos_next = (pos_reg < PW'(POS_CAP)) ? pos_reg + PW'(1) : pos_reg;

        if (pos_next <= PW'(MIN_PAYLOAD)) begin
            verdict_next = VERDICT_SHORT;
        end else if (found_next) begin
            verdict_next = VERDICT_MATCH;
        end else begin
            verdict_next = VERDICT_NO_MATCH;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_LEAD;
            pos_reg     <= '0;
            lit_reg     <= '0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            verdict_reg <= VERDICT_NO_MATCH;
        end else begin
            if (accept) begin
                if (s_tlast) begin
                    phase_reg   <= PH_LEAD;
                    pos_reg     <= '0;
                    lit_reg     <= '0;
                    found_reg   <= 1'b0;
                    m_valid_reg <= 1'b1;
                    verdict_reg <= verdict_next;
                end else begin
                    phase_reg <= phase_next;
                    pos_reg   <= pos_next;
                    lit_reg   <= lit_next;
                    found_reg <= found_next;
                    if (m_tready) begin
                        m_valid_reg <= 1'b0;
                    end
                end
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/pilm_checker.sv -----
`default_nettype none

module pilm_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       s_tlast,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);
    import pilm_pkg::*;

    // A pending verdict that is stalled stays offered.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("stalled verdict dropped");

    // Every last byte that is accepted yields a verdict in the next cycle.
    a_last_gives_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("no verdict after last byte");

    // A last byte is never taken while a verdict waits unconsumed.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready && s_tlast |-> !s_tready)
        else $error("last byte accepted over a pending verdict");

    // The verdict word carries a valid code and zero padding.
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:2] == 6'd0)
            && (m_tdata[1:0] == VERDICT_NO_MATCH || m_tdata[1:0] == VERDICT_MATCH
                || m_tdata[1:0] == VERDICT_SHORT))
        else $error("bad verdict word");

endmodule

bind printer_idle_line_matcher_top pilm_checker u_pilm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
